@@ rtl/core/sfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    localparam logic [7:0] C_START_FIRST  = 8'h4C;
    localparam logic [7:0] C_START_SECOND = 8'h4D;

    localparam int unsigned C_BUFFER_DEPTH = 64;

    localparam logic [7:0]  C_MIN_LENGTH_RST    = 8'd2;
    localparam logic [7:0]  C_MAX_LENGTH_RST    = 8'd64;
    localparam logic [15:0] C_TIMEOUT_TICKS_RST = 16'd10;

    localparam logic [1:0] C_REG_MIN_LENGTH    = 2'd0;
    localparam logic [1:0] C_REG_MAX_LENGTH    = 2'd1;
    localparam logic [1:0] C_REG_TIMEOUT_TICKS = 2'd2;

    localparam logic C_CMD_BYTE = 1'b0;
    localparam logic C_CMD_TICK = 1'b1;

    localparam logic [1:0] C_EVT_NONE     = 2'd0;
    localparam logic [1:0] C_EVT_STORED   = 2'd1;
    localparam logic [1:0] C_EVT_COMPLETE = 2'd2;
    localparam logic [1:0] C_EVT_TIMEOUT  = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] byte_index;
        logic [7:0] byte_value;
        logic       checksum_ok;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/core/serial_frame_deframer_xor.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_stall   i_in_item  (cmd, rx_byte)
// out       source     o_out_valid / i_out_stall o_out_item (event_res, byte_index,
//                                                  byte_value, checksum_ok)
// cfg       sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_stall is low; each transfer yields exactly one result, which is registered.
// Frame state updates in the cycle of the input transfer; an output register plus a
// skid register hold results, so input keeps flowing while one result waits.
// o_in_stall rises only when both output registers are full.
// Synchronous active-low reset returns to hunting the first start byte with
// registers at their defaults.

module serial_frame_deframer_xor #(
    parameter int unsigned BUFFER_DEPTH = sfd_pkg::C_BUFFER_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  sfd_pkg::t_in_item i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output sfd_pkg::t_out_item  o_out_item,
    input  wire                 i_cfg_we,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [15:0]         i_cfg_data
);

    import sfd_pkg::*;

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_BODY  = 3'd3;
    localparam logic [2:0] PH_CSUM  = 3'd4;

    localparam logic [7:0] BUF_DEPTH = 8'(BUFFER_DEPTH);

    logic [7:0]  r_min_length;
    logic [7:0]  r_max_length;
    logic [15:0] r_timeout_ticks;

    logic [2:0]  r_phase,        n_phase;
    logic [7:0]  r_fill_index,   n_fill_index;
    logic [7:0]  r_frame_length, n_frame_length;
    logic [7:0]  r_running_xor,  n_running_xor;
    logic [15:0] r_idle_count,   n_idle_count;
    logic        r_in_frame,     n_in_frame;

    logic        r_out_valid, r_skid_valid;
    t_out_item   r_out, r_skid;

    t_out_item   n_result;
    logic        in_xfer;
    logic        out_free;
    logic [15:0] idle_inc;
    logic [7:0]  rx_b;
    logic [7:0]  store_len;
    logic [7:0]  fill_next;

    assign in_xfer  = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign rx_b     = i_in_item.rx_byte;
    assign idle_inc = (r_idle_count == 16'hFFFF) ? r_idle_count : r_idle_count + 16'd1;
    assign fill_next = r_fill_index + 8'd1;
    assign store_len = (r_phase == PH_LEN) ? rx_b : r_frame_length;

    always_comb begin
        n_phase        = r_phase;
        n_fill_index   = r_fill_index;
        n_frame_length = r_frame_length;
        n_running_xor  = r_running_xor;
        n_idle_count   = r_idle_count;
        n_in_frame     = r_in_frame;
        n_result       = '0;

        if (i_in_item.cmd == C_CMD_TICK) begin
            if (r_in_frame) begin
                n_idle_count = idle_inc;
                if (idle_inc >= r_timeout_ticks) begin
                    n_result.event_res = C_EVT_TIMEOUT;
                    n_phase            = PH_HUNT1;
                    n_in_frame         = 1'b0;
                    n_idle_count       = '0;
                end
            end
        end else begin
            unique case (r_phase)
                PH_HUNT1: begin
                    if (rx_b == C_START_FIRST) begin
                        n_phase      = PH_HUNT2;
                        n_in_frame   = 1'b1;
                        n_idle_count = '0;
                    end
                end
                PH_HUNT2: begin
                    if (rx_b == C_START_SECOND) begin
                        n_phase       = PH_LEN;
                        n_fill_index  = '0;
                        n_running_xor = '0;
                    end
                end
                PH_LEN, PH_BODY: begin
                    if (r_phase == PH_LEN && (rx_b < r_min_length || rx_b > r_max_length)) begin
                        n_phase    = PH_HUNT1;
                        n_in_frame = 1'b0;
                    end else begin
                        n_frame_length = store_len;
                        n_idle_count   = '0;
                        if (r_fill_index >= BUF_DEPTH) begin
                            n_phase = PH_CSUM;
                        end else begin
                            if (r_fill_index != 8'd0) begin
                                n_running_xor = r_running_xor ^ rx_b;
                            end
                            n_result.event_res  = C_EVT_STORED;
                            n_result.byte_index = r_fill_index;
                            n_result.byte_value = rx_b;
                            n_fill_index        = fill_next;
                            n_phase = (fill_next >= store_len) ? PH_CSUM : PH_BODY;
                        end
                    end
                end
                PH_CSUM: begin
                    n_result.event_res   = C_EVT_COMPLETE;
                    n_result.byte_index  = r_fill_index;
                    n_result.checksum_ok = (rx_b == r_running_xor);
                    n_phase              = PH_HUNT1;
                    n_in_frame           = 1'b0;
                end
                default: begin
                    n_phase = PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length    <= C_MIN_LENGTH_RST;
            r_max_length    <= C_MAX_LENGTH_RST;
            r_timeout_ticks <= C_TIMEOUT_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                C_REG_MIN_LENGTH:    r_min_length    <= i_cfg_data[7:0];
                C_REG_MAX_LENGTH:    r_max_length    <= i_cfg_data[7:0];
                C_REG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT1;
            r_fill_index   <= '0;
            r_frame_length <= '0;
            r_running_xor  <= '0;
            r_idle_count   <= '0;
            r_in_frame     <= 1'b0;
        end else if (in_xfer) begin
            r_phase        <= n_phase;
            r_fill_index   <= n_fill_index;
            r_frame_length <= n_frame_length;
            r_running_xor  <= n_running_xor;
            r_idle_count   <= n_idle_count;
            r_in_frame     <= n_in_frame;
        end
    end

    // hold results in the output register, overflow into the skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || in_xfer;
                r_skid_valid <= 1'b0;
            end else if (in_xfer) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (!out_free && in_xfer) begin
            r_skid <= n_result;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
